// ===== sv/mm2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_pkg
// Shared types, constants and helpers for the MurmurHash2 string hash core.
// ----------------------------------------------------------------------------
package mm2_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam logic [31:0] SEED_RESET = 32'h811c9dc5;
  localparam int unsigned FIN_SHIFT1 = 13;
  localparam int unsigned FIN_SHIFT2 = 15;

  // how the back end folds a chunk into the running hash
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } kind_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL1,
    FE_MUL2
  } fe_state_t;

  // one classified chunk on its way from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] data;
    logic        first;
    logic        last;
    logic [31:0] key_length;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [31:0] mul_m(input logic [31:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(MIX_MUL);
    return p[31:0];
  endfunction

  function automatic kind_t classify(input logic [2:0] count);
    kind_t k;
    if (count >= 3'd4) begin
      k = KIND_FULL;
    end else if (count == 3'd0) begin
      k = KIND_NONE;
    end else begin
      k = KIND_TAIL;
    end
    return k;
  endfunction

  // drop bytes at or above count
  function automatic logic [31:0] tail_mask(input logic [31:0] chunk,
                                            input logic [2:0]  count);
    logic [31:0] m;
    unique case (count)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return chunk & m;
  endfunction

endpackage

// ===== sv/murmur2_string_hash_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_string_hash_core
// 32-bit MurmurHash2 of a key streamed as little-endian four-byte chunks.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: present key_chunk/byte_count/first_chunk/last_chunk/
//   key_length with push; a transfer happens when push is high and full low.
//   key_length counts only on a chunk marked first_chunk.
//   Result queue: hash_value is valid while empty is low; pop takes it.
//   Only a chunk marked last_chunk produces a result.
//   Seed: cfg_data is written when cfg_valid and cfg_ready are high
//   (cfg_ready is always high); write it only while the core is idle.
// Timing:
//   The front end takes a new chunk only as it queues the previous one, after
//   its two chained multiplies of the full-word premix. The back end folds a
//   chunk per cycle unless a finalization waits on a held result. A stalled
//   result holds the result register; once a further last chunk waits, the
//   back end stops, the chunk queue (QUEUE_DEPTH entries) fills, then full rises.
// Reset: seed = 0x811c9dc5, running hash = 0, both queues empty.
// ----------------------------------------------------------------------------
module murmur2_string_hash_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] key_chunk,
  input  logic [2:0]  byte_count,
  input  logic        first_chunk,
  input  logic        last_chunk,
  input  logic [31:0] key_length,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import mm2_pkg::*;

  logic [31:0] seed;
  logic        q_push;
  logic        q_pop;
  entry_t      q_wr_entry;
  entry_t      q_rd_entry;
  q_stat_t     q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed <= cfg_data;
    end
  end

  mm2_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .key_chunk   (key_chunk),
    .byte_count  (byte_count),
    .first_chunk (first_chunk),
    .last_chunk  (last_chunk),
    .key_length  (key_length),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_entry     (q_wr_entry)
  );

  mm2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .rd_en    (q_pop),
    .rd_entry (q_rd_entry),
    .stat     (q_stat)
  );

  mm2_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .q_stat     (q_stat),
    .q_entry    (q_rd_entry),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .hash_value (hash_value)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("chunk queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("chunk queue read while empty");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front end took a chunk while the premix was busy");
`endif

endmodule

// ===== sv/mm2_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_front
// Input side: takes chunks, classifies them and premixes full words
// (k * m, k ^= k >> 24, k * m) in states FE_MUL1 and FE_MUL2 before queuing them.
// ----------------------------------------------------------------------------
module mm2_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [31:0]       key_chunk,
  input  logic [2:0]        byte_count,
  input  logic              first_chunk,
  input  logic              last_chunk,
  input  logic [31:0]       key_length,
  input  mm2_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output mm2_pkg::entry_t   q_entry
);
  import mm2_pkg::*;

  fe_state_t   state;
  fe_state_t   state_next;
  logic        take;
  logic [31:0] chunk;
  kind_t       kind;
  logic        first;
  logic        last;
  logic [31:0] klen;
  logic [31:0] k1;
  logic [31:0] k1_mixed;

  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: begin
        if (push) state_next = FE_MUL1;
      end
      FE_MUL1: state_next = FE_MUL2;
      FE_MUL2: begin
        if (!q_stat.full) state_next = push ? FE_MUL1 : FE_IDLE;
      end
      default: state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    unique case (state)
      FE_IDLE: full = 1'b0;
      FE_MUL1: full = 1'b1;
      FE_MUL2: begin
        // next chunk may enter in the cycle the current one is queued
        full   = q_stat.full;
        q_push = !q_stat.full;
      end
      default: full = 1'b1;
    endcase
  end

  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chunk <= tail_mask(key_chunk, byte_count);
      kind  <= classify(byte_count);
      first <= first_chunk;
      last  <= last_chunk;
      klen  <= key_length;
    end
    if (state == FE_MUL1) begin
      k1 <= (kind == KIND_FULL) ? mul_m(chunk) : chunk;
    end
  end

  assign k1_mixed = k1 ^ (k1 >> MIX_SHIFT);

  always_comb begin
    q_entry.kind       = kind;
    q_entry.data       = (kind == KIND_FULL) ? mul_m(k1_mixed) : k1;
    q_entry.first      = first;
    q_entry.last       = last;
    q_entry.key_length = klen;
  end

endmodule

// ===== sv/mm2_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_queue
// Short FIFO of classified chunks between the front and the back end.
// ----------------------------------------------------------------------------
module mm2_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  mm2_pkg::entry_t  wr_entry,
  input  logic             rd_en,
  output mm2_pkg::entry_t  rd_entry,
  output mm2_pkg::q_stat_t stat
);
  import mm2_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= bump(wr_ptr);
      if (rd_en) rd_ptr <= bump(rd_ptr);
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  assign rd_entry   = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

endmodule

// ===== sv/mm2_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2_back
// Back end: folds queued chunks into the running hash, one per cycle unless a
// finalization stalls; a last chunk's 13/15 finalization goes to the result register.
// ----------------------------------------------------------------------------
module mm2_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      seed,
  input  mm2_pkg::q_stat_t q_stat,
  input  mm2_pkg::entry_t  q_entry,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      hash_value
);
  import mm2_pkg::*;

  logic [31:0] running_hash;
  logic [31:0] running_hash_next;
  logic [31:0] h0;
  logic        fin_pend;
  logic        fin_go;
  logic        res_valid;
  logic [31:0] fin_x;
  logic [31:0] fin_m;

  // finalization reads running_hash before the next chunk overwrites it
  assign fin_go = fin_pend && (!res_valid || pop);
  assign q_pop  = !q_stat.empty && (!fin_pend || fin_go);

  assign h0 = q_entry.first ? (seed ^ q_entry.key_length) : running_hash;

  always_comb begin
    unique case (q_entry.kind)
      KIND_FULL: running_hash_next = mul_m(h0) ^ q_entry.data;
      KIND_TAIL: running_hash_next = mul_m(h0 ^ q_entry.data);
      KIND_NONE: running_hash_next = h0;
      default:   running_hash_next = h0;
    endcase
  end

  assign fin_x = running_hash ^ (running_hash >> FIN_SHIFT1);
  assign fin_m = mul_m(fin_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      fin_pend     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (q_pop) running_hash <= running_hash_next;
      if (q_pop && q_entry.last) begin
        fin_pend <= 1'b1;
      end else if (fin_go) begin
        fin_pend <= 1'b0;
      end
      if (fin_go) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) hash_value <= fin_m ^ (fin_m >> FIN_SHIFT2);
  end

  assign empty = !res_valid;

endmodule

// ===== tb/murmur2_hash_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash_checker
// Watches the chunk, result and seed channels of the MurmurHash2 core, keeps
// its own running hash and seed, and compares every popped hash in order.
// ----------------------------------------------------------------------------
module murmur2_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] key_chunk,
  input  logic [2:0]  byte_count,
  input  logic        first_chunk,
  input  logic        last_chunk,
  input  logic [31:0] key_length,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] hash_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          hashes_pending,
  output int          fail_count
);
  import mm2_pkg::*;

  localparam logic [2:0] WORD_BYTES = 3'd4;

  logic [31:0] hash_seed;
  logic [31:0] key_hash;
  logic [31:0] hash_q[$];
  int          errs;

  // fold one chunk into the running hash; counts above four act as a full word
  function automatic logic [31:0] fold_chunk(input logic [31:0] h,
                                             input logic [31:0] data,
                                             input logic [2:0]  count);
    logic [31:0] k;
    logic [31:0] g;
    if (count >= WORD_BYTES) begin
      k = data * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      g = (h * MIX_MUL) ^ k;
    end else begin
      g = h;
      if (count >= 3'd3) g = g ^ {8'h00, data[23:16], 16'h0000};
      if (count >= 3'd2) g = g ^ {16'h0000, data[15:8], 8'h00};
      if (count >= 3'd1) begin
        g = g ^ {24'h000000, data[7:0]};
        g = g * MIX_MUL;
      end
    end
    return g;
  endfunction

  function automatic logic [31:0] final_avalanche(input logic [31:0] h);
    logic [31:0] g;
    g = h ^ (h >> FIN_SHIFT1);
    g = g * MIX_MUL;
    g = g ^ (g >> FIN_SHIFT2);
    return g;
  endfunction

  always @(posedge clk) begin : watch
    logic [31:0] want;
    if (rst) begin
      hash_seed = SEED_RESET;
      key_hash  = '0;
      hash_q.delete();
      errs      = 0;
    end else begin
      if (pop && !empty) begin
        if (hash_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected hash transfer: expected none, actual %08h",
                   $time, hash_value);
        end else begin
          want = hash_q.pop_front();
          if (hash_value !== want) begin
            errs++;
            $display("%0t: hash_value mismatch: expected %08h, actual %08h",
                     $time, want, hash_value);
          end
        end
      end
      if (cfg_valid && cfg_ready) hash_seed = cfg_data;
      if (push && !full) begin
        // key_length only matters on the opening chunk of a key
        if (first_chunk) key_hash = hash_seed ^ key_length;
        key_hash = fold_chunk(key_hash, key_chunk, byte_count);
        // finalization is not written back into the running hash
        if (last_chunk) hash_q.push_back(final_avalanche(key_hash));
      end
    end
    hashes_pending <= hash_q.size();
    fail_count     <= errs;
  end

endmodule

// ===== tb/murmur2_string_hash_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_string_hash_core_tb
// Streams directed and random keys into the MurmurHash2 core under several
// seeds, with bursty input and a stalling result side; the checker predicts.
// ----------------------------------------------------------------------------
module murmur2_string_hash_core_tb;
  import mm2_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_CHUNKS = 1830;
  localparam int PHASES        = 6;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        push        = 1'b0;
  logic        full;
  logic [31:0] key_chunk   = '0;
  logic [2:0]  byte_count  = '0;
  logic        first_chunk = 1'b0;
  logic        last_chunk  = 1'b0;
  logic [31:0] key_length  = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [31:0] hash_value;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data    = '0;

  int hashes_pending;
  int fail_count;
  int chunks_sent   = 0;
  int keys_closed   = 0;
  int seeds_written = 0;
  int burst_left    = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_cnt      = 0;
  int pop_mode      = 0;
  int mode_cnt      = 0;
  int idle_cycles   = 0;

  always #5 clk = ~clk;

  murmur2_string_hash_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .key_chunk   (key_chunk),
    .byte_count  (byte_count),
    .first_chunk (first_chunk),
    .last_chunk  (last_chunk),
    .key_length  (key_length),
    .empty       (empty),
    .pop         (pop),
    .hash_value  (hash_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  murmur2_hash_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .key_chunk      (key_chunk),
    .byte_count     (byte_count),
    .first_chunk    (first_chunk),
    .last_chunk     (last_chunk),
    .key_length     (key_length),
    .empty          (empty),
    .pop            (pop),
    .hash_value     (hash_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .hashes_pending (hashes_pending),
    .fail_count     (fail_count)
  );

  // result side: stall pattern switches mode now and then; a hold request
  // from the stimulus blocks pops for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      hold_seen <= 0;
      hold_cnt  <= 0;
      pop_mode  <= 0;
      mode_cnt  <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      pop      <= 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        pop_mode <= $urandom_range(0, 3);
        mode_cnt <= $urandom_range(8, 80);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (pop_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= ($urandom_range(0, 4) == 0);
        default: pop <= ~pop;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_chunk(input logic [31:0] data, input logic [2:0] count,
                            input logic first, input logic last,
                            input logic [31:0] klen);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 16);
    end
    key_chunk   <= data;
    byte_count  <= count;
    first_chunk <= first;
    last_chunk  <= last;
    key_length  <= klen;
    push        <= 1'b1;
    do @(posedge clk); while (full);
    burst_left--;
    chunks_sent++;
    if (last) keys_closed++;
  endtask

  // well-formed key of n bytes; key_length is random on later chunks
  task automatic send_key(input int n, input logic [31:0] klen);
    int nfull;
    int rem;
    nfull = n / 4;
    rem   = n % 4;
    if (n == 0) send_chunk($urandom, 3'd0, 1'b1, 1'b1, klen);
    for (int i = 0; i < nfull; i++) begin
      send_chunk($urandom, 3'd4, i == 0, (i == nfull - 1) && (rem == 0),
                 (i == 0) ? klen : 32'($urandom));
    end
    if (rem != 0) begin
      send_chunk($urandom, 3'(rem), nfull == 0, 1'b1,
                 (nfull == 0) ? klen : 32'($urandom));
    end
  endtask

  // stop sending and wait for every hash, plus chunks still in flight
  task automatic drain;
    push <= 1'b0;
    do @(posedge clk); while (hashes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seeds_written++;
  endtask

  initial begin
    logic [31:0] seeds [PHASES];
    int          target;
    int          r;
    int          n;
    logic        mid_drained;

    mid_drained = 1'b0;
    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hffff_ffff;
    seeds[2] = $urandom;
    seeds[3] = SEED_RESET;
    seeds[4] = $urandom;
    seeds[5] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed keys at the reset seed
    send_chunk(32'h1234_5678, 3'd4, 1'b0, 1'b1, 32'h0);   // no key started yet
    send_chunk(32'hdead_beef, 3'd0, 1'b1, 1'b1, 32'h0);   // empty key
    send_chunk(32'hff63_6261, 3'd3, 1'b1, 1'b1, 32'd3);
    send_chunk(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'hffff_ffff);
    send_chunk(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd4);
    send_chunk(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b1, 32'd4);   // oversized counts
    send_chunk(32'ha5a5_a5a5, 3'd6, 1'b1, 1'b1, 32'd4);
    send_chunk(32'ha5a5_a5a5, 3'd7, 1'b1, 1'b1, 32'd4);
    send_chunk(32'hffff_ff80, 3'd1, 1'b1, 1'b1, 32'd1);   // junk in upper bytes
    send_chunk(32'hffff_7f01, 3'd2, 1'b1, 1'b1, 32'd2);
    send_chunk(32'h0bad_4142, 3'd2, 1'b1, 1'b0, 32'd6);   // short, not last
    send_chunk(32'h4645_4443, 3'd4, 1'b0, 1'b1, 32'h0);
    send_chunk(32'h7777_7777, 3'd4, 1'b0, 1'b1, 32'h0);   // continue after a hash
    send_chunk(32'h6867_6665, 3'd4, 1'b1, 1'b0, 32'd9);
    send_chunk(32'h6c6b_6a69, 3'd4, 1'b0, 1'b0, 32'hffff_ffff);
    send_chunk(32'h3333_336d, 3'd1, 1'b0, 1'b1, 32'h0);
    send_chunk(32'h8000_0001, 3'd4, 1'b1, 1'b0, 32'd7);
    send_chunk(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0);   // empty chunk mid-key
    send_chunk(32'h0102_0304, 3'd3, 1'b0, 1'b1, 32'h0);
    send_chunk(32'h5555_5555, 3'd0, 1'b1, 1'b0, 32'h0);
    send_chunk(32'haaaa_aaaa, 3'd4, 1'b0, 1'b1, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      write_seed(seeds[p]);
      target = chunks_sent + RANDOM_CHUNKS / PHASES;
      if (p == 1) hold_req <= hold_req + 1;
      while (chunks_sent < target) begin
        if (p == 2 && !mid_drained
            && chunks_sent >= target - RANDOM_CHUNKS / (2 * PHASES)) begin
          drain();
          mid_drained = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 86) begin
          n = (r < 78) ? $urandom_range(0, 24) : $urandom_range(25, 64);
          send_key(n, ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'(n));
        end else begin
          send_chunk($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom);
        end
      end
    end

    drain();
    $display("Run covered %0d chunks closing %0d keys under %0d written seeds,",
             chunks_sent, keys_closed, seeds_written);
    $display("with bursty input, a long result hold-off and a mid-phase drain.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
